// ===== rtl/node_health_alert_limiter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions checked outside of reset.
// ----------------------------------------------------------------------------
`ifndef NODE_HEALTH_ALERT_LIMITER_MACROS_SVH
`define NODE_HEALTH_ALERT_LIMITER_MACROS_SVH

// Same-cycle implication.
`define NHAL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NHAL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nhal_pkg.sv =====
// ----------------------------------------------------------------------------
// nhal_pkg
// Alert kinds, register indexes, reset values and widths of the limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package nhal_pkg;

  localparam int unsigned TIME_BITS_DEFAULT = 32;
  localparam int unsigned NOW_W             = 32;
  localparam int unsigned SPAN_W            = 19;
  localparam int unsigned CFG_INDEX_W       = 3;
  localparam int unsigned CFG_DATA_W        = 16;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_ONLINE  = 3'd1,
    KIND_OFFLINE = 3'd2,
    KIND_V4_ON   = 3'd3,
    KIND_V4_OFF  = 3'd4,
    KIND_V6_ON   = 3'd5,
    KIND_V6_OFF  = 3'd6,
    KIND_CPU     = 3'd7
  } kind_t;

  localparam logic [CFG_INDEX_W-1:0] REG_OFFLINE_DELAY   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_INTERVAL = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CPU_LIMIT       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CPU_HOLD        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_IPV6_ALERTS_OFF = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_REPEATS     = 3'd5;

  localparam logic [15:0] OFFLINE_DELAY_RST   = 16'd120;
  localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd300;
  localparam logic [6:0]  CPU_LIMIT_RST       = 7'd90;
  localparam logic [15:0] CPU_HOLD_RST        = 16'd180;
  localparam logic [2:0]  MAX_REPEATS_RST     = 3'd3;
  localparam logic [SPAN_W-1:0] V6_WINDOW_SLACK = 19'd10;

endpackage

`default_nettype wire

// ===== rtl/node_health_alert_limiter.sv =====
// ----------------------------------------------------------------------------
// node_health_alert_limiter
// Turns node status samples into rate-limited health alerts.
// One sample (link, IPv4, IPv6, CPU load, time in seconds) enters per beat on
// the input channel; each sample yields zero or one alert beat on the output
// channel (kind, repeat count, CPU peak). Loss of link, IPv4 and IPv6 is
// debounced by offline_delay, CPU overload by cpu_hold; one condition wins by
// fixed priority and repeats of a kind are spaced and capped.
// Each sample is held in the input register, and its alert in the output register.
// Throughput: one sample per cycle while the receiver does not stall; the
// single update stage on the state registers sets this figure.
// The config channel is always ready; write it only while the block is idle.
// Reset clears all stamps and history and loads the register defaults.
// When the receiver stalls, the result beat holds; one more sample waits in
// the input register, then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module node_health_alert_limiter #(
  parameter int unsigned TIME_BITS = nhal_pkg::TIME_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                link_up,
  input  wire logic                                ipv4_online,
  input  wire logic                                ipv6_online,
  input  wire logic [6:0]                          cpu_load,
  input  wire logic [nhal_pkg::NOW_W-1:0]          now,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [2:0]                               alert_kind,
  output logic [2:0]                               repeat_count,
  output logic [6:0]                               cpu_peak,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [nhal_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [nhal_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned CMP_W =
    (TIME_BITS > nhal_pkg::SPAN_W) ? TIME_BITS : nhal_pkg::SPAN_W;

  function automatic logic [CMP_W-1:0] span(input logic [TIME_BITS-1:0] t_now,
                                            input logic [TIME_BITS-1:0] t_stamp);
    logic [TIME_BITS-1:0] diff;
    diff = t_now - t_stamp;
    return CMP_W'(diff);
  endfunction

  logic [15:0] offline_delay;
  logic [15:0] repeat_interval;
  logic [6:0]  cpu_limit;
  logic [15:0] cpu_hold;
  logic        ipv6_alerts_off;
  logic [2:0]  max_repeats;

  logic                 in_q_valid;
  logic                 link_q;
  logic                 v4_q;
  logic                 v6_q;
  logic [6:0]           load_q;
  logic [TIME_BITS-1:0] now_q;

  logic [TIME_BITS-1:0] link_lost_stamp, link_lost_stamp_next;
  logic [TIME_BITS-1:0] v4_lost_stamp, v4_lost_stamp_next;
  logic [TIME_BITS-1:0] v6_lost_stamp, v6_lost_stamp_next;
  logic [TIME_BITS-1:0] overload_stamp, overload_stamp_next;
  logic [6:0]           load_peak, load_peak_next;
  nhal_pkg::kind_t      last_kind, last_kind_next;
  logic [TIME_BITS-1:0] last_sent_stamp, last_sent_stamp_next;
  logic [2:0]           sent_count, sent_count_next;

  logic                 in_take;
  logic                 fire;
  logic                 over;
  logic                 emit;
  nhal_pkg::kind_t      kind;
  logic [CMP_W-1:0]     e_link, e_v4, e_v6, e_cpu, e_sent;
  logic [CMP_W-1:0]     delay_w, hold_w, v6_top, rep_limit;
  logic [nhal_pkg::SPAN_W-1:0] v6_top_s;
  logic [nhal_pkg::SPAN_W-1:0] rep_prod;

  assign cfg_ready = 1'b1;
  assign fire      = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = in_q_valid && !fire;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      offline_delay   <= nhal_pkg::OFFLINE_DELAY_RST;
      repeat_interval <= nhal_pkg::REPEAT_INTERVAL_RST;
      cpu_limit       <= nhal_pkg::CPU_LIMIT_RST;
      cpu_hold        <= nhal_pkg::CPU_HOLD_RST;
      ipv6_alerts_off <= 1'b0;
      max_repeats     <= nhal_pkg::MAX_REPEATS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nhal_pkg::REG_OFFLINE_DELAY:   offline_delay   <= cfg_data;
        nhal_pkg::REG_REPEAT_INTERVAL: repeat_interval <= cfg_data;
        nhal_pkg::REG_CPU_LIMIT:       cpu_limit       <= cfg_data[6:0];
        nhal_pkg::REG_CPU_HOLD:        cpu_hold        <= cfg_data;
        nhal_pkg::REG_IPV6_ALERTS_OFF: ipv6_alerts_off <= cfg_data[0];
        nhal_pkg::REG_MAX_REPEATS:     max_repeats     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      link_q <= link_up;
      v4_q   <= ipv4_online;
      v6_q   <= ipv6_online;
      load_q <= cpu_load;
      now_q  <= TIME_BITS'(now);
    end
  end

  assign delay_w   = CMP_W'(offline_delay);
  assign hold_w    = CMP_W'(cpu_hold);
  assign v6_top_s  = nhal_pkg::SPAN_W'(offline_delay)
                     + {(nhal_pkg::SPAN_W-1)'(repeat_interval), 1'b0}
                     + nhal_pkg::V6_WINDOW_SLACK;
  assign v6_top    = CMP_W'(v6_top_s);
  assign rep_prod  = nhal_pkg::SPAN_W'(sent_count) * nhal_pkg::SPAN_W'(repeat_interval);
  assign rep_limit = CMP_W'(rep_prod);

  assign over   = load_q >= cpu_limit;
  assign e_link = span(now_q, link_lost_stamp);
  assign e_v4   = span(now_q, v4_lost_stamp);
  assign e_v6   = span(now_q, v6_lost_stamp);
  assign e_cpu  = span(now_q, overload_stamp_next);
  assign e_sent = span(now_q, last_sent_stamp);

  always_comb begin
    if (over) begin
      overload_stamp_next = (overload_stamp == '0) ? now_q : overload_stamp;
      load_peak_next      = (load_q > load_peak) ? load_q : load_peak;
    end else begin
      overload_stamp_next = '0;
      load_peak_next      = '0;
    end
  end

  always_comb begin
    kind                 = nhal_pkg::KIND_NONE;
    link_lost_stamp_next = link_lost_stamp;
    v4_lost_stamp_next   = v4_lost_stamp;
    v6_lost_stamp_next   = v6_lost_stamp;
    if (!link_q) begin
      if (link_lost_stamp == '0) begin
        link_lost_stamp_next = now_q;
      end else if (e_link > delay_w) begin
        kind = nhal_pkg::KIND_OFFLINE;
      end
    end else if (link_lost_stamp != '0) begin
      if (e_link > delay_w) begin
        kind = nhal_pkg::KIND_ONLINE;
      end
      link_lost_stamp_next = '0;
    end else if (!v4_q) begin
      if (v4_lost_stamp == '0) begin
        v4_lost_stamp_next = now_q;
      end else if (e_v4 > delay_w) begin
        kind = nhal_pkg::KIND_V4_OFF;
      end
    end else if (v4_lost_stamp != '0) begin
      if (e_v4 > delay_w) begin
        kind = nhal_pkg::KIND_V4_ON;
      end
      v4_lost_stamp_next = '0;
    end else if (!ipv6_alerts_off && !v6_q) begin
      if (v6_lost_stamp == '0) begin
        v6_lost_stamp_next = now_q;
      end else if (e_v6 > delay_w && e_v6 < v6_top) begin
        kind = nhal_pkg::KIND_V6_OFF;
      end
    end else if (!ipv6_alerts_off && v6_lost_stamp != '0) begin
      if (e_v6 > delay_w) begin
        kind = nhal_pkg::KIND_V6_ON;
      end
      v6_lost_stamp_next = '0;
    end
    if (kind == nhal_pkg::KIND_NONE && over && overload_stamp_next != '0
        && e_cpu > hold_w) begin
      kind = nhal_pkg::KIND_CPU;
    end
  end

  always_comb begin
    emit                 = 1'b0;
    last_kind_next       = last_kind;
    last_sent_stamp_next = last_sent_stamp;
    sent_count_next      = sent_count;
    if (kind == nhal_pkg::KIND_NONE) begin
      last_kind_next       = nhal_pkg::KIND_NONE;
      last_sent_stamp_next = '0;
      sent_count_next      = '0;
    end else if (kind != last_kind) begin
      emit                 = 1'b1;
      last_kind_next       = kind;
      last_sent_stamp_next = now_q;
      sent_count_next      = 3'd1;
    end else if (sent_count < max_repeats && e_sent > rep_limit) begin
      emit                 = 1'b1;
      last_sent_stamp_next = now_q;
      sent_count_next      = sent_count + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_lost_stamp <= '0;
      v4_lost_stamp   <= '0;
      v6_lost_stamp   <= '0;
      overload_stamp  <= '0;
      load_peak       <= '0;
      last_kind       <= nhal_pkg::KIND_NONE;
      last_sent_stamp <= '0;
      sent_count      <= '0;
    end else if (fire) begin
      link_lost_stamp <= link_lost_stamp_next;
      v4_lost_stamp   <= v4_lost_stamp_next;
      v6_lost_stamp   <= v6_lost_stamp_next;
      overload_stamp  <= overload_stamp_next;
      load_peak       <= load_peak_next;
      last_kind       <= last_kind_next;
      last_sent_stamp <= last_sent_stamp_next;
      sent_count      <= sent_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      alert_kind   <= kind;
      repeat_count <= sent_count_next;
      cpu_peak     <= (kind == nhal_pkg::KIND_CPU) ? load_peak_next : 7'd0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nhal_checker.sv =====
// ----------------------------------------------------------------------------
// nhal_checker
// Port-level checks of the alert limiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "node_health_alert_limiter_macros.svh"

module nhal_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] alert_kind,
  input wire logic [2:0] repeat_count,
  input wire logic [6:0] cpu_peak
);

  `NHAL_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(alert_kind) && $stable(repeat_count) && $stable(cpu_peak),
    "stalled alert beat changed")

  `NHAL_ASSERT_IMP(a_kind_count, out_valid,
    alert_kind != nhal_pkg::KIND_NONE && repeat_count != 3'd0,
    "alert beat without kind or count")

  `NHAL_ASSERT_IMP(a_peak_cpu_only, out_valid && alert_kind != nhal_pkg::KIND_CPU,
    cpu_peak == 7'd0,
    "cpu peak set on a non-cpu alert")

  `NHAL_ASSERT_IMP(a_no_stall_when_empty, !out_valid,
    !in_stall,
    "input stalled while output register is empty")

endmodule

bind node_health_alert_limiter nhal_checker u_nhal_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .alert_kind   (alert_kind),
  .repeat_count (repeat_count),
  .cpu_peak     (cpu_peak)
);

`default_nettype wire
